[design/cta_pkg.sv]
// Shared types and constants of the completion tag allocator.
`default_nettype none
package cta_pkg;

   localparam int IDX_W = 12;
   localparam int TAG_W = 13;
   localparam int PAY_W = 64;
   localparam int RES_W = 32;

   localparam logic [TAG_W-1:0] TAG_BASE   = 13'd1024;
   localparam logic [PAY_W-1:0] TAG_IGNORE = 64'd0;
   localparam logic [PAY_W-1:0] TAG_WAKE   = 64'd1;

   localparam logic ACT_ALLOCATE = 1'b0;

   typedef enum logic [2:0] {
      ST_ALLOCATED    = 3'd0,
      ST_FULL         = 3'd1,
      ST_DISPATCHED   = 3'd2,
      ST_IGNORED      = 3'd3,
      ST_WAKE         = 3'd4,
      ST_UNRECOGNIZED = 3'd5,
      ST_BAD_TAG      = 3'd6
   } cta_status_type;

   typedef enum logic [2:0] {
      K_NO_CALLBACK = 3'd0,
      K_ALLOC       = 3'd1,
      K_RELEASE     = 3'd2,
      K_IGNORE      = 3'd3,
      K_WAKE        = 3'd4,
      K_UNRECOGNIZED = 3'd5,
      K_OUT_OF_RANGE = 3'd6
   } cta_kind_type;

   typedef struct packed {
      cta_kind_type             kind;
      logic [IDX_W-1:0]         idx;
      logic signed [PAY_W-1:0]  payload;
      logic signed [RES_W-1:0]  result;
   } cta_op_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } cta_state_type;

endpackage
`default_nettype wire

[design/completion_tag_allocator.sv]
// Top level of the completion tag allocator: front end, operation queue, back end.
//
//   Channel   Handshake              Payload
//   req_      req_valid/req_ready    action, wants_callback, payload, completion tag/result
//   rsp_      rsp_valid/rsp_ready    status, tag, entry_payload, result_out, entry_index
//
// In the back end each transaction first reads the table word at the free-list head or
// the released index, then updates it and loads the result once the result register is free.
// A two-entry queue lets the front accept while the back end works or the result stalls.
// Reset builds the free list implicitly through a fresh-entry counter; no clearing pass.
// The back end takes a new transaction only after the read-then-update sequence of
// the last one is done.
`default_nettype none
module completion_tag_allocator
   import cta_pkg::*;
#(
   parameter int ENTRIES = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_action,
   input  wire logic                req_wants_callback,
   input  wire logic signed [63:0]  req_payload,
   input  wire logic [63:0]         req_completion_tag,
   input  wire logic signed [31:0]  req_completion_result,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_status,
   output logic [12:0]              rsp_tag,
   output logic signed [63:0]       rsp_entry_payload,
   output logic signed [31:0]       rsp_result_out,
   output logic [11:0]              rsp_entry_index
);

   cta_op_type  front_op;
   cta_op_type  head_op;
   logic        q_full;
   logic        q_empty;
   logic        q_pop;

   assign req_ready = !q_full;

   cta_front #(.ENTRIES(ENTRIES)) u_front (
      .req_action            (req_action),
      .req_wants_callback    (req_wants_callback),
      .req_payload           (req_payload),
      .req_completion_tag    (req_completion_tag),
      .req_completion_result (req_completion_result),
      .op                    (front_op)
   );

   cta_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_valid && req_ready),
      .push_op (front_op),
      .pop     (q_pop),
      .full    (q_full),
      .empty   (q_empty),
      .head_op (head_op)
   );

   cta_back #(.ENTRIES(ENTRIES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (head_op),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_tag           (rsp_tag),
      .rsp_entry_payload (rsp_entry_payload),
      .rsp_result_out    (rsp_result_out),
      .rsp_entry_index   (rsp_entry_index)
   );

endmodule
`default_nettype wire

[design/cta_front.sv]
// Front end: classifies an incoming transaction into a queued operation.
`default_nettype none
module cta_front
   import cta_pkg::*;
#(
   parameter int ENTRIES = 256
) (
   input  wire logic                 req_action,
   input  wire logic                 req_wants_callback,
   input  wire logic signed [63:0]   req_payload,
   input  wire logic [63:0]          req_completion_tag,
   input  wire logic signed [31:0]   req_completion_result,
   output cta_op_type                op
);

   localparam logic [63:0] TAG_LIMIT = 64'(1024 + ENTRIES);

   logic [63:0] tag_offset;

   assign tag_offset = req_completion_tag - 64'(TAG_BASE);

   always_comb begin
      op.idx     = tag_offset[IDX_W-1:0];
      op.payload = req_payload;
      op.result  = req_completion_result;
      if (req_action == ACT_ALLOCATE) begin
         op.kind = req_wants_callback ? K_ALLOC : K_NO_CALLBACK;
      end else if (req_completion_tag >= 64'(TAG_BASE)) begin
         op.kind = (req_completion_tag < TAG_LIMIT) ? K_RELEASE : K_OUT_OF_RANGE;
      end else if (req_completion_tag == TAG_IGNORE) begin
         op.kind = K_IGNORE;
      end else if (req_completion_tag == TAG_WAKE) begin
         op.kind = K_WAKE;
      end else begin
         op.kind = K_UNRECOGNIZED;
      end
   end

endmodule
`default_nettype wire

[design/cta_queue.sv]
// Two-entry queue of classified operations between the front and back ends.
`default_nettype none
module cta_queue
   import cta_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire cta_op_type  push_op,
   input  wire logic        pop,
   output logic             full,
   output logic             empty,
   output cta_op_type       head_op
);

   cta_op_type  slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head_op = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

[design/cta_back.sv]
// Back end: free-list table, busy marks, stored payloads and the result register.
`default_nettype none
module cta_back
   import cta_pkg::*;
#(
   parameter int ENTRIES = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire cta_op_type           q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [TAG_W-1:0]          rsp_tag,
   output logic signed [PAY_W-1:0]   rsp_entry_payload,
   output logic signed [RES_W-1:0]   rsp_result_out,
   output logic [IDX_W-1:0]          rsp_entry_index
);

   localparam int IW = $clog2(ENTRIES);
   localparam int LW = IW + 1;
   localparam int MW = 1 + LW + PAY_W;
   localparam logic [LW-1:0] EMPTY_MARK = LW'(ENTRIES);

   // Table word: busy mark, free-list link, stored payload.
   logic [MW-1:0]   table_ff [ENTRIES];
   logic [MW-1:0]   rd_word_ff;
   logic [IW-1:0]   rd_idx;
   logic            wr_en;
   logic [MW-1:0]   wr_word;

   cta_state_type   state_ff, state_in;
   cta_op_type      op_ff, op_in;
   logic [IW-1:0]   addr_ff, addr_in;
   logic [LW-1:0]   free_head_ff, free_head_in;
   // Entries at or above this index have never been handed out, so their link
   // is implicitly index + 1 and their busy mark is clear.
   logic [LW-1:0]   fresh_ff, fresh_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   cta_status_type          rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]        rsp_tag_ff, rsp_tag_in;
   logic signed [PAY_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic signed [RES_W-1:0] rsp_result_ff, rsp_result_in;
   logic [IDX_W-1:0]        rsp_index_ff, rsp_index_in;

   logic                rd_busy;
   logic [LW-1:0]       rd_link;
   logic [PAY_W-1:0]    rd_payload;
   logic                out_free;
   logic                entry_live;

   assign rd_busy    = rd_word_ff[MW-1];
   assign rd_link    = rd_word_ff[PAY_W +: LW];
   assign rd_payload = rd_word_ff[PAY_W-1:0];
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign entry_live = (LW'(addr_ff) < fresh_ff) && rd_busy;

   assign rd_idx = (state_ff == S_IDLE)
                 ? ((q_head.kind == K_ALLOC) ? free_head_ff[IW-1:0] : q_head.idx[IW-1:0])
                 : addr_ff;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      addr_in        = addr_ff;
      free_head_in   = free_head_ff;
      fresh_in       = fresh_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;
      wr_word        = rd_word_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_result_in  = rsp_result_ff;
      rsp_index_in   = rsp_index_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               op_in    = q_head;
               addr_in  = rd_idx;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_tag_in     = '0;
               rsp_payload_in = '0;
               rsp_result_in  = '0;
               rsp_index_in   = '0;
               case (op_ff.kind)
                  K_NO_CALLBACK:  rsp_status_in = ST_ALLOCATED;
                  K_ALLOC: begin
                     if (free_head_ff >= EMPTY_MARK) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_ALLOCATED;
                        rsp_tag_in    = TAG_W'(addr_ff) + TAG_BASE;
                        rsp_index_in  = IDX_W'(addr_ff);
                        wr_en         = 1'b1;
                        wr_word       = {1'b1, rd_link, op_ff.payload};
                        if (free_head_ff == fresh_ff) begin
                           free_head_in = free_head_ff + LW'(1);
                           fresh_in     = fresh_ff + LW'(1);
                        end else begin
                           free_head_in = rd_link;
                        end
                     end
                  end
                  K_RELEASE: begin
                     if (entry_live) begin
                        rsp_status_in  = ST_DISPATCHED;
                        rsp_payload_in = rd_payload;
                        rsp_result_in  = op_ff.result;
                        rsp_index_in   = IDX_W'(addr_ff);
                        wr_en          = 1'b1;
                        wr_word        = {1'b0, free_head_ff, rd_payload};
                        free_head_in   = LW'(addr_ff);
                     end else begin
                        rsp_status_in = ST_BAD_TAG;
                     end
                  end
                  K_IGNORE:       rsp_status_in = ST_IGNORED;
                  K_WAKE:         rsp_status_in = ST_WAKE;
                  K_UNRECOGNIZED: rsp_status_in = ST_UNRECOGNIZED;
                  default:        rsp_status_in = ST_BAD_TAG;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      addr_ff        <= addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_result_ff  <= rsp_result_in;
      rsp_index_ff   <= rsp_index_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[addr_ff] <= wr_word;
      end
      rd_word_ff <= table_ff[rd_idx];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_tag           = rsp_tag_ff;
   assign rsp_entry_payload = rsp_payload_ff;
   assign rsp_result_out    = rsp_result_ff;
   assign rsp_entry_index   = rsp_index_ff;

`ifndef NO_ASSERTIONS
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= EMPTY_MARK)
      else $error("free-list head beyond the empty mark");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= EMPTY_MARK && (free_head_ff <= fresh_ff || free_head_ff == EMPTY_MARK))
      else $error("fresh pointer inconsistent with free-list head");

   a_load_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result loaded outside the execute state");

   a_tag_matches_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_ALLOCATED && rsp_tag_ff != '0)
         |-> rsp_tag_ff == TAG_W'(rsp_index_ff) + TAG_BASE)
      else $error("allocated tag does not match entry index");
`endif

endmodule
`default_nettype wire

[test/completion_tag_allocator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the completion tag allocator with a free-list predictor.
module completion_tag_allocator_tb;
   import cta_pkg::*;

   localparam int ENTRIES = 256;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic ACT_COMPLETE = ~ACT_ALLOCATE;

   typedef struct packed {
      logic               action;
      logic               wants_callback;
      logic signed [63:0] payload;
      logic [63:0]        ctag;
      logic signed [31:0] cres;
   } tag_request_t;

   typedef struct packed {
      cta_status_type     status;
      logic [12:0]        tag;
      logic signed [63:0] entry_payload;
      logic signed [31:0] result_out;
      logic [11:0]        entry_index;
   } tag_response_t;

   typedef enum int {PH_MIXED, PH_FILL, PH_NOISE, PH_DRAIN} phase_kind_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_action = ACT_ALLOCATE;
   logic               req_wants_callback = 1'b0;
   logic signed [63:0] req_payload = '0;
   logic [63:0]        req_completion_tag = '0;
   logic signed [31:0] req_completion_result = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic [12:0]        rsp_tag;
   logic signed [63:0] rsp_entry_payload;
   logic signed [31:0] rsp_result_out;
   logic [11:0]        rsp_entry_index;

   completion_tag_allocator #(.ENTRIES(ENTRIES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_wants_callback(req_wants_callback),
      .req_payload(req_payload),
      .req_completion_tag(req_completion_tag),
      .req_completion_result(req_completion_result),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_tag(rsp_tag),
      .rsp_entry_payload(rsp_entry_payload),
      .rsp_result_out(rsp_result_out),
      .rsp_entry_index(rsp_entry_index)
   );

   // Shadow copy of the tag table.
   logic [12:0]        next_free [ENTRIES];
   logic signed [63:0] slot_payload [ENTRIES];
   logic               slot_busy [ENTRIES];
   logic [12:0]        free_head;

   tag_request_t  pending_requests [$];
   tag_response_t expected_responses [$];
   int            live_slots [$];
   logic [63:0]   last_released_tag;
   int            queued_count = 0;
   int            accepted_count = 0;
   int            failures = 0;
   int            cycle_count = 0;
   int            burst_left = 0;
   int            gap_left = 0;
   int            stall_mode = 0;
   int            mode_left = 0;
   int            stall_tick = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic clear_tag_table();
      for (int i = 0; i < ENTRIES; i++) begin
         next_free[i] = 13'(i + 1);
         slot_payload[i] = '0;
         slot_busy[i] = 1'b0;
      end
      free_head = '0;
   endtask

   // Applies one transaction to the shadow table and returns the response it causes.
   function automatic tag_response_t predict_response(input tag_request_t r);
      tag_response_t o;
      logic [63:0] offset;
      int slot;
      o = '0;
      o.status = ST_ALLOCATED;
      if (r.action == ACT_ALLOCATE) begin
         if (r.wants_callback) begin
            if (free_head >= ENTRIES) begin
               o.status = ST_FULL;
            end else begin
               slot = free_head;
               free_head = next_free[slot];
               slot_payload[slot] = r.payload;
               slot_busy[slot] = 1'b1;
               o.tag = TAG_BASE + 13'(slot);
               o.entry_index = 12'(slot);
            end
         end
      end else if (r.ctag >= 64'(TAG_BASE)) begin
         offset = r.ctag - 64'(TAG_BASE);
         if (offset >= 64'(ENTRIES) || !slot_busy[int'(offset)]) begin
            o.status = ST_BAD_TAG;
         end else begin
            slot = int'(offset);
            o.status = ST_DISPATCHED;
            o.entry_payload = slot_payload[slot];
            o.result_out = r.cres;
            o.entry_index = 12'(slot);
            slot_busy[slot] = 1'b0;
            next_free[slot] = free_head;
            free_head = 13'(slot);
         end
      end else if (r.ctag == TAG_IGNORE) begin
         o.status = ST_IGNORED;
      end else if (r.ctag == TAG_WAKE) begin
         o.status = ST_WAKE;
      end else begin
         o.status = ST_UNRECOGNIZED;
      end
      return o;
   endfunction

   task automatic queue_request(input logic action, input logic wants_callback,
                                input logic [63:0] payload, input logic [63:0] ctag,
                                input logic [31:0] cres);
      tag_request_t r;
      r.action = action;
      r.wants_callback = wants_callback;
      r.payload = payload;
      r.ctag = ctag;
      r.cres = cres;
      pending_requests.push_back(r);
      queued_count++;
   endtask

   // Fields that the operation does not use are filled with noise.
   task automatic queue_allocate(input logic wants_callback, input logic [63:0] payload);
      queue_request(ACT_ALLOCATE, wants_callback, payload, rand64(), $urandom);
   endtask

   task automatic queue_completion(input logic [63:0] ctag, input logic [31:0] cres);
      queue_request(ACT_COMPLETE, $urandom_range(0, 1), rand64(), ctag, cres);
   endtask

   function automatic logic [63:0] take_live_tag();
      int pick;
      logic [63:0] t;
      pick = $urandom_range(0, live_slots.size() - 1);
      t = 64'(TAG_BASE) + 64'(live_slots[pick]);
      live_slots.delete(pick);
      last_released_tag = t;
      return t;
   endfunction

   task automatic wait_until_idle();
      while (accepted_count != queued_count || expected_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input phase_kind_t kind, input int length, input int budget);
      int count;
      int sel;
      wait_until_idle();
      live_slots = {};
      for (int i = 0; i < ENTRIES; i++)
         if (slot_busy[i]) live_slots.push_back(i);
      count = length;
      if (kind == PH_FILL) count = ENTRIES - live_slots.size() + $urandom_range(2, 8);
      if (kind == PH_DRAIN) count = live_slots.size() + $urandom_range(0, 10);
      if (count > budget) count = budget;
      for (int n = 0; n < count; n++) begin
         case (kind)
            PH_FILL: begin
               if ($urandom_range(0, 15) == 0)
                  queue_completion(64'($urandom_range(0, 1023)), $urandom);
               else
                  queue_allocate(1'b1, rand64());
            end
            PH_DRAIN: begin
               if (live_slots.size() != 0 && $urandom_range(0, 7) != 0)
                  queue_completion(take_live_tag(), $urandom);
               else
                  queue_allocate(1'b1, rand64());
            end
            PH_MIXED: begin
               if ($urandom_range(0, 1) == 0)
                  queue_allocate($urandom_range(0, 7) != 0, rand64());
               else if (live_slots.size() != 0)
                  queue_completion(take_live_tag(), $urandom);
               else
                  queue_completion(64'($urandom_range(0, 1023)), $urandom);
            end
            default: begin
               sel = $urandom_range(0, 5);
               case (sel)
                  0: queue_allocate(1'b0, rand64());
                  1: queue_completion(rand64(), $urandom);
                  2: queue_completion(64'(TAG_BASE) + 64'($urandom_range(0, ENTRIES + 15)),
                                      $urandom);
                  3: queue_completion(64'($urandom_range(0, 1023)), $urandom);
                  4: queue_completion(last_released_tag, $urandom);
                  default: queue_allocate(1'b1, rand64());
               endcase
            end
         endcase
      end
   endtask

   // Stimulus: directed cases first, then phases of random traffic.
   initial begin
      phase_kind_t order [5];
      int phase_index;
      int directed_count;
      order = '{PH_MIXED, PH_FILL, PH_NOISE, PH_DRAIN, PH_MIXED};
      last_released_tag = 64'(TAG_BASE);
      clear_tag_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      queue_allocate(1'b0, 64'h7FFF_FFFF_FFFF_FFFF);
      queue_completion(TAG_IGNORE, 32'h8000_0000);
      queue_completion(TAG_WAKE, 32'h7FFF_FFFF);
      queue_completion(64'd2, $urandom);
      queue_completion(64'(TAG_BASE) - 64'd1, $urandom);
      queue_completion(64'(TAG_BASE), $urandom);
      queue_completion(64'(TAG_BASE) + 64'(ENTRIES), $urandom);
      queue_completion(64'hFFFF_FFFF_FFFF_FFFF, $urandom);
      // Low bits alias a valid tag; the upper bits must still reject it.
      queue_completion(64'h0000_0001_0000_0400, $urandom);
      queue_allocate(1'b1, 64'h8000_0000_0000_0000);
      queue_allocate(1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
      queue_allocate(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_allocate(1'b0, rand64());
      queue_completion(64'(TAG_BASE) + 64'd1, 32'h7FFF_FFFF);
      queue_completion(64'(TAG_BASE) + 64'd1, $urandom);
      queue_completion(64'(TAG_BASE), 32'h8000_0000);
      queue_allocate(1'b1, 64'd0);
      queue_completion(64'(TAG_BASE) + 64'd2, 32'd0);
      queue_completion(64'(TAG_BASE) + 64'(ENTRIES - 1), $urandom);
      directed_count = queued_count;

      phase_index = 0;
      while (queued_count < directed_count + RANDOM_ITEMS) begin
         run_phase(order[phase_index % 5], $urandom_range(20, 80),
                   directed_count + RANDOM_ITEMS - queued_count);
         phase_index++;
      end

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_responses.size() != 0) begin
         $error("%0d responses never arrived", expected_responses.size());
         failures++;
      end
      if (failures == 0) begin
         $display("completion_tag_allocator_tb: PASS");
      end else begin
         $display("completion_tag_allocator_tb: FAIL");
      end
      $finish;
   end

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      tag_request_t r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            r.action = req_action;
            r.wants_callback = req_wants_callback;
            r.payload = req_payload;
            r.ctag = req_completion_tag;
            r.cres = req_completion_result;
            expected_responses.push_back(predict_response(r));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               r = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_action <= r.action;
               req_wants_callback <= r.wants_callback;
               req_payload <= r.payload;
               req_completion_tag <= r.ctag;
               req_completion_result <= r.cres;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 32);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         failures++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // Response monitor; the ready pattern switches between several stall modes.
   always @(posedge clock) begin
      tag_response_t e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               failures++;
               $error("response transaction with no request outstanding");
            end else begin
               e = expected_responses.pop_front();
               check_field("status", 64'(e.status), 64'(rsp_status));
               check_field("tag", 64'(e.tag), 64'(rsp_tag));
               check_field("entry_payload", e.entry_payload, rsp_entry_payload);
               check_field("result_out", 64'(e.result_out), 64'(rsp_result_out));
               check_field("entry_index", 64'(e.entry_index), 64'(rsp_entry_index));
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 200);
         end else begin
            mode_left--;
         end
         stall_tick++;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (stall_tick % 3 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("completion_tag_allocator_tb: FAIL");
         $finish;
      end
   end

endmodule
